FILE: rtl/core/ddc_pkg.sv
// Package with the types, constants and arithmetic helpers of the down-converter core.
`default_nettype none
package ddc_pkg;

   localparam int SAMPLE_WIDTH  = 16;
   localparam int MIX_W         = SAMPLE_WIDTH + 1;
   localparam int PH_W          = 18;
   localparam int TAP_W         = 16;
   localparam int MAX_TAPS      = 257;
   localparam int RENORM_PERIOD = 4096;
   localparam int IDX_W         = $clog2(MAX_TAPS);
   localparam int REN_W         = $clog2(RENORM_PERIOD);
   localparam int DEC_W         = 13;
   localparam int ACC_W         = 48;
   localparam int K_W           = 22;
   localparam int CSR_W         = 18;
   localparam int ONE_Q16       = 65536;
   localparam int THREE_Q16     = 196608;

   typedef enum logic [1:0] {
      KIND_SAMPLE  = 2'd0,
      KIND_COEF    = 2'd1,
      KIND_RESTART = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_STEP_RE   = 2'd0,
      CSR_STEP_IM   = 2'd1,
      CSR_TAP_COUNT = 2'd2,
      CSR_DECIM     = 2'd3
   } csr_index_type;

   typedef struct packed {
      kind_type                        kind;
      logic signed [SAMPLE_WIDTH-1:0]  i_sample;
      logic signed [SAMPLE_WIDTH-1:0]  q_sample;
      logic [IDX_W-1:0]                coef_index;
      logic signed [TAP_W-1:0]         coef_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] out_i;
      logic signed [SAMPLE_WIDTH-1:0] out_q;
   } rsp_type;

   typedef logic signed [ACC_W-1:0] wide_type;

   function automatic wide_type rnd_sh(wide_type v, int s);
      wide_type half;
      half = wide_type'(1) <<< (s - 1);
      return (v + half) >>> s;
   endfunction

   function automatic wide_type sat_w(wide_type v, int w);
      wide_type hi;
      wide_type lo;
      hi = (wide_type'(1) <<< (w - 1)) - wide_type'(1);
      lo = -hi - wide_type'(1);
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ddc_mixer_fir_decimator_core.sv
// Top level of the down-converter: phasor mixer, circular delay line and decimating FIR.
// A sample transaction goes through mixing, phasor advance and the delay-line write,
// through the renormalization steps on every renormalization instant, and on a
// decimation instant through a FIR pass in which one multiply-accumulate per cycle walks
// the delay-line memory and the tap memory over n taps, n being the active tap count.
// After reset and after each restart a clearing pass writes zeros to all 257 delay-line
// entries, one per cycle, during which no transaction is accepted.
`default_nettype none
module ddc_mixer_fir_decimator_core
   import ddc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              csr_we,
   input  wire csr_index_type     csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_MUL, S_ADD, S_RN1, S_RN2, S_RN3, S_RN4, S_WR, S_FIR, S_OUT
   } state_type;

   state_type state_ff;

   logic signed [PH_W-1:0]          step_re_ff, step_im_ff;
   logic [IDX_W-1:0]                tap_count_ff;
   logic [DEC_W-1:0]                decim_ff;

   logic signed [PH_W-1:0]          phre_ff, phim_ff;
   logic [REN_W-1:0]                ren_cnt_ff;
   logic [IDX_W-1:0]                wp_ff;
   logic [DEC_W-1:0]                dec_cnt_ff;
   logic [IDX_W-1:0]                clr_ff;
   logic signed [SAMPLE_WIDTH-1:0]  xi_ff, xq_ff;
   wide_type                        m0_ff, m1_ff, m2_ff, m3_ff;
   wide_type                        s0_ff, s1_ff, s2_ff, s3_ff;
   logic signed [MIX_W-1:0]         mr_ff, mi_ff;
   logic signed [K_W-1:0]           k_ff;
   logic [IDX_W-1:0]                rd_idx_ff, t_ff;
   logic [2*MIX_W-1:0]              dl_q_ff;
   logic signed [TAP_W-1:0]         tap_q_ff;
   logic                            v1_ff, v2_ff;
   logic signed [MIX_W+TAP_W-1:0]   fpi_ff, fpq_ff;
   wide_type                        acc_i_ff, acc_q_ff;
   logic                            rsp_valid_ff;
   rsp_type                         rsp_data_ff;

   logic [2*MIX_W-1:0]              dl_mem [MAX_TAPS];
   logic signed [TAP_W-1:0]         tap_mem [MAX_TAPS];

   logic [IDX_W-1:0]                n_eff, wp_eff, wp_next, rd_next;
   logic [DEC_W-1:0]                dec_eff;
   logic                            dl_we, tap_we, issue, accept, out_free;
   logic [IDX_W-1:0]                dl_waddr;
   logic [2*MIX_W-1:0]              dl_wdata;
   wide_type                        fin_i, fin_q;

   assign n_eff = (tap_count_ff == '0) ? IDX_W'(1) :
                  ((tap_count_ff > IDX_W'(MAX_TAPS)) ? IDX_W'(MAX_TAPS) : tap_count_ff);
   assign wp_eff  = (wp_ff < n_eff) ? wp_ff : '0;
   assign wp_next = (wp_eff + IDX_W'(1) == n_eff) ? '0 : wp_eff + IDX_W'(1);
   assign rd_next = (rd_idx_ff + IDX_W'(1) == n_eff) ? '0 : rd_idx_ff + IDX_W'(1);
   assign dec_eff = (decim_ff == '0) ? DEC_W'(1) : decim_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign issue     = (state_ff == S_FIR) && (t_ff != n_eff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign tap_we   = accept && (req_data.kind == KIND_COEF) &&
                     (req_data.coef_index < IDX_W'(MAX_TAPS));
   assign dl_we    = (state_ff == S_CLR) || (state_ff == S_WR);
   assign dl_waddr = (state_ff == S_CLR) ? clr_ff : wp_eff;
   assign dl_wdata = (state_ff == S_CLR) ? '0 : {mr_ff, mi_ff};

   assign fin_i = sat_w(rnd_sh(acc_i_ff, 15), SAMPLE_WIDTH);
   assign fin_q = sat_w(rnd_sh(acc_q_ff, 15), SAMPLE_WIDTH);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[dl_waddr] <= dl_wdata;
      end
      dl_q_ff <= dl_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (tap_we) begin
         tap_mem[req_data.coef_index] <= req_data.coef_value;
      end
      tap_q_ff <= tap_mem[t_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_re_ff <= PH_W'(ONE_Q16);
         step_im_ff <= '0;
         tap_count_ff <= IDX_W'(MAX_TAPS);
         decim_ff <= DEC_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_STEP_RE:   step_re_ff <= csr_wdata[PH_W-1:0];
            CSR_STEP_IM:   step_im_ff <= csr_wdata[PH_W-1:0];
            CSR_TAP_COUNT: tap_count_ff <= csr_wdata[IDX_W-1:0];
            CSR_DECIM:     decim_ff <= csr_wdata[DEC_W-1:0];
            default:       tap_count_ff <= tap_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         phre_ff <= PH_W'(ONE_Q16);
         phim_ff <= '0;
         ren_cnt_ff <= '0;
         wp_ff <= '0;
         dec_cnt_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         if (v1_ff) begin
            fpi_ff <= (MIX_W+TAP_W)'($signed(dl_q_ff[2*MIX_W-1:MIX_W]) * tap_q_ff);
            fpq_ff <= (MIX_W+TAP_W)'($signed(dl_q_ff[MIX_W-1:0]) * tap_q_ff);
         end
         if (v2_ff) begin
            acc_i_ff <= acc_i_ff + ACC_W'(fpi_ff);
            acc_q_ff <= acc_q_ff + ACC_W'(fpq_ff);
         end
         if (issue) begin
            t_ff <= t_ff + IDX_W'(1);
            rd_idx_ff <= rd_next;
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + IDX_W'(1);
               if (clr_ff == IDX_W'(MAX_TAPS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  case (req_data.kind)
                     KIND_SAMPLE: begin
                        xi_ff <= req_data.i_sample;
                        xq_ff <= req_data.q_sample;
                        state_ff <= S_MUL;
                     end
                     KIND_RESTART: begin
                        phre_ff <= PH_W'(ONE_Q16);
                        phim_ff <= '0;
                        ren_cnt_ff <= '0;
                        wp_ff <= '0;
                        dec_cnt_ff <= '0;
                        clr_ff <= '0;
                        state_ff <= S_CLR;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_MUL: begin
               m0_ff <= ACC_W'(xi_ff * phre_ff);
               m1_ff <= ACC_W'(xq_ff * phim_ff);
               m2_ff <= ACC_W'(xi_ff * phim_ff);
               m3_ff <= ACC_W'(xq_ff * phre_ff);
               s0_ff <= ACC_W'(phre_ff * step_re_ff);
               s1_ff <= ACC_W'(phim_ff * step_im_ff);
               s2_ff <= ACC_W'(phre_ff * step_im_ff);
               s3_ff <= ACC_W'(phim_ff * step_re_ff);
               state_ff <= S_ADD;
            end
            S_ADD: begin
               mr_ff <= MIX_W'(sat_w(rnd_sh(m0_ff - m1_ff, 16), MIX_W));
               mi_ff <= MIX_W'(sat_w(rnd_sh(m2_ff + m3_ff, 16), MIX_W));
               phre_ff <= PH_W'(sat_w(rnd_sh(s0_ff - s1_ff, 16), PH_W));
               phim_ff <= PH_W'(sat_w(rnd_sh(s2_ff + s3_ff, 16), PH_W));
               if (ren_cnt_ff == REN_W'(RENORM_PERIOD - 1)) begin
                  ren_cnt_ff <= '0;
                  state_ff <= S_RN1;
               end else begin
                  ren_cnt_ff <= ren_cnt_ff + REN_W'(1);
                  state_ff <= S_WR;
               end
            end
            S_RN1: begin
               m0_ff <= ACC_W'(phre_ff * phre_ff);
               m1_ff <= ACC_W'(phim_ff * phim_ff);
               state_ff <= S_RN2;
            end
            S_RN2: begin
               k_ff <= K_W'(wide_type'(THREE_Q16) - rnd_sh(m0_ff + m1_ff, 16));
               state_ff <= S_RN3;
            end
            S_RN3: begin
               m0_ff <= ACC_W'(phre_ff * k_ff);
               m1_ff <= ACC_W'(phim_ff * k_ff);
               state_ff <= S_RN4;
            end
            S_RN4: begin
               phre_ff <= PH_W'(sat_w(rnd_sh(m0_ff, 17), PH_W));
               phim_ff <= PH_W'(sat_w(rnd_sh(m1_ff, 17), PH_W));
               state_ff <= S_WR;
            end
            S_WR: begin
               wp_ff <= wp_next;
               if ({1'b0, dec_cnt_ff} + (DEC_W+1)'(1) < {1'b0, dec_eff}) begin
                  dec_cnt_ff <= dec_cnt_ff + DEC_W'(1);
                  state_ff <= S_IDLE;
               end else begin
                  dec_cnt_ff <= '0;
                  rd_idx_ff <= wp_next;
                  t_ff <= '0;
                  acc_i_ff <= '0;
                  acc_q_ff <= '0;
                  state_ff <= S_FIR;
               end
            end
            S_FIR: begin
               if ((t_ff == n_eff) && !v1_ff && !v2_ff) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_data_ff.out_i <= SAMPLE_WIDTH'(fin_i);
                  rsp_data_ff.out_q <= SAMPLE_WIDTH'(fin_q);
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/ddc_core_checker.sv
// Port-level checker for the down-converter core, bound to its top level.
`default_nettype none
module ddc_core_checker
   import ddc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid && !req_ready)
      else $error("Core shows activity right after reset.");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("Result transaction raised while the core was idle.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Pending result transaction changed or vanished.");

endmodule

bind ddc_mixer_fir_decimator_core ddc_core_checker u_ddc_core_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
